// ----- rtl/core/sidac_pkg.sv -----
// Shared constants and types for the signed integer to decimal ASCII converter.
// Used by every module under rtl/core; depends on nothing else.
package sidac_pkg;

  // word and character widths
  localparam int unsigned WordW     = 32;
  localparam int unsigned CharW     = 8;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW      = NumDigits * DigitW;
  localparam int unsigned CountW    = $clog2(NumDigits + 1);
  localparam int unsigned IterW     = $clog2(WordW);

  // default depth of the queue between front and back
  localparam int unsigned QueueDepthDefault = 2;

  // ascii codes
  localparam logic [CharW-1:0] AsciiZero  = 8'd48;
  localparam logic [CharW-1:0] AsciiNine  = 8'd57;
  localparam logic [CharW-1:0] AsciiMinus = 8'd45;

  // classified number handed from front to back
  typedef struct packed {
    logic             neg;
    logic [WordW-1:0] mag;
  } item_t;

endpackage

// ----- rtl/core/sidac_front.sv -----
// Front stage: takes one signed integer per transfer, splits it into sign and magnitude.
// Depends on sidac_pkg.
module sidac_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic signed [sidac_pkg::WordW-1:0] value_i,
  output logic                              item_valid_o,
  input  logic                              item_ready_i,
  output sidac_pkg::item_t                  item_o
);

  logic             valid_q;
  sidac_pkg::item_t item_q;
  sidac_pkg::item_t item_d;
  logic [sidac_pkg::WordW-1:0] bits;
  logic             accept;

  // hold the item while the queue is full
  assign full_o = valid_q && !item_ready_i;
  assign accept = push_i && !full_o;

  // sign and magnitude; the most negative value wraps to its unsigned magnitude
  assign bits       = value_i;
  assign item_d.neg = bits[sidac_pkg::WordW-1];
  assign item_d.mag = item_d.neg ? (~bits + 1'b1) : bits;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (item_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ----- rtl/core/sidac_fifo.sv -----
// Short queue of classified numbers between the front and the back stage.
// Depends on sidac_pkg for the item type.
module sidac_fifo #(
  parameter int unsigned Depth = sidac_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sidac_pkg::item_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output sidac_pkg::item_t data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sidac_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o = mem_q[rd_ptr_q];

endmodule

// ----- rtl/core/sidac_conv.sv -----
// Back stage: shift-add-3 binary to BCD conversion, then one character per transfer.
// Depends on sidac_pkg; takes classified numbers from sidac_fifo.
module sidac_conv (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          item_valid_i,
  input  sidac_pkg::item_t              item_i,
  output logic                          item_pop_o,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [sidac_pkg::CharW-1:0]   text_char_o,
  output logic                          last_o
);

  localparam int unsigned WordW  = sidac_pkg::WordW;
  localparam int unsigned BcdW   = sidac_pkg::BcdW;
  localparam int unsigned DigitW = sidac_pkg::DigitW;
  localparam int unsigned CountW = sidac_pkg::CountW;
  localparam int unsigned IterW  = sidac_pkg::IterW;
  localparam int unsigned CharW  = sidac_pkg::CharW;

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StSkip,
    StSign,
    StEmit
  } state_e;

  state_e              state_q;
  logic                neg_q;
  logic [WordW-1:0]    bin_q;
  logic [BcdW-1:0]     bcd_q;
  logic [IterW-1:0]    iter_q;
  logic [CountW-1:0]   left_q;
  logic                out_valid_q;
  logic [CharW-1:0]    char_q;
  logic                last_q;

  logic [BcdW-1:0]     bcd_adj;
  logic [DigitW-1:0]   top_digit;
  logic                out_load;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    logic [DigitW-1:0] nib;
    for (int i = 0; i < sidac_pkg::NumDigits; i++) begin
      nib = bcd_q[i*DigitW +: DigitW];
      bcd_adj[i*DigitW +: DigitW] = (nib >= DigitW'(5)) ? nib + DigitW'(3) : nib;
    end
  end

  assign top_digit  = bcd_q[BcdW-1 -: DigitW];
  assign out_load   = !out_valid_q || pop_i;
  assign item_pop_o = (state_q == StIdle) && item_valid_i;

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      neg_q       <= 1'b0;
      bin_q       <= '0;
      bcd_q       <= '0;
      iter_q      <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && pop_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (item_valid_i) begin
            neg_q   <= item_i.neg;
            bin_q   <= item_i.mag;
            bcd_q   <= '0;
            iter_q  <= '0;
            state_q <= StConv;
          end
        end
        StConv: begin
          {bcd_q, bin_q} <= {bcd_adj[BcdW-2:0], bin_q, 1'b0};
          iter_q <= iter_q + 1'b1;
          if (iter_q == IterW'(WordW - 1)) begin
            left_q  <= CountW'(sidac_pkg::NumDigits);
            state_q <= StSkip;
          end
        end
        // drop leading zeros, keeping at least one digit
        StSkip: begin
          if (top_digit == '0 && left_q != CountW'(1)) begin
            bcd_q  <= {bcd_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
            left_q <= left_q - 1'b1;
          end else begin
            state_q <= neg_q ? StSign : StEmit;
          end
        end
        StSign: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            char_q      <= sidac_pkg::AsciiMinus;
            last_q      <= 1'b0;
            state_q     <= StEmit;
          end
        end
        StEmit: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            char_q      <= sidac_pkg::AsciiZero + CharW'(top_digit);
            last_q      <= (left_q == CountW'(1));
            bcd_q       <= {bcd_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
            left_q      <= left_q - 1'b1;
            if (left_q == CountW'(1)) begin
              state_q <= StIdle;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign empty_o     = !out_valid_q;
  assign text_char_o = char_q;
  assign last_o      = last_q;

endmodule

// ----- rtl/core/signed_int_to_decimal_ascii_top.sv -----
// Signed 32-bit integer to decimal ASCII text, one character per output transfer.
// Depends on sidac_pkg, sidac_front, sidac_fifo and sidac_conv.
//
// Each number pushed in comes out as its decimal text: a minus sign for a negative
// value, then the digits from most significant down with no leading zeros, zero
// giving a single '0'; last marks the final character and no NUL follows. Both
// sides are queues: push while full is low, pop while empty is low. In the back
// stage a number is fetched, run through 32 shift-add-3 steps of the binary to BCD
// loop, stripped of its leading zero digits one at a time, then sent as a minus sign
// when negative and then one digit per character, each character waiting for pop;
// dropped zeros and digits always add up to ten. The front register and the queue
// of QueueDepth entries take new numbers while the back stage is busy.
module signed_int_to_decimal_ascii_top #(
  parameter int unsigned QueueDepth = sidac_pkg::QueueDepthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  output logic                               full_o,
  input  logic signed [sidac_pkg::WordW-1:0] value_i,
  output logic                               empty_o,
  input  logic                               pop_i,
  output logic [sidac_pkg::CharW-1:0]        text_char_o,
  output logic                               last_o
);

  sidac_pkg::item_t front_item;
  sidac_pkg::item_t queue_item;
  logic             front_valid;
  logic             queue_full;
  logic             queue_empty;
  logic             queue_pop;

  // accept and classify
  sidac_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .value_i      (value_i),
    .item_valid_o (front_valid),
    .item_ready_i (!queue_full),
    .item_o       (front_item)
  );

  // decoupling queue
  sidac_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .data_o  (queue_item),
    .empty_o (queue_empty)
  );

  // convert and emit
  sidac_conv u_conv (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!queue_empty),
    .item_i       (queue_item),
    .item_pop_o   (queue_pop),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .text_char_o  (text_char_o),
    .last_o       (last_o)
  );

endmodule

// ----- rtl/core/sidac_checker.sv -----
// Port-level checks for the signed integer to decimal ASCII converter.
// Depends on sidac_pkg; bound to signed_int_to_decimal_ascii_top below.
module sidac_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               full_o,
  input logic                               empty_o,
  input logic                               pop_i,
  input logic [sidac_pkg::CharW-1:0]        text_char_o,
  input logic                               last_o
);

  // reset leaves both queues idle
  assert property (@(posedge clk_i) !rst_ni |=> (empty_o && !full_o))
    else $error("not idle in reset");

  // a waiting result holds until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(text_char_o) && $stable(last_o)))
    else $error("stalled result changed");

  // only a minus sign or a decimal digit is shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> ((text_char_o == sidac_pkg::AsciiMinus) ||
                  (text_char_o >= sidac_pkg::AsciiZero &&
                   text_char_o <= sidac_pkg::AsciiNine)))
    else $error("character out of range");

  // a minus sign never ends a number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && text_char_o == sidac_pkg::AsciiMinus) |-> !last_o)
    else $error("minus marked last");

  // the first digit after a transferred minus is never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && pop_i && text_char_o == sidac_pkg::AsciiMinus) ##1 !empty_o
      |-> (text_char_o != sidac_pkg::AsciiZero))
    else $error("leading zero after minus");

endmodule

bind signed_int_to_decimal_ascii_top sidac_checker u_checker (.*);
